// ===== sv/greedy_nearest_track_associator_macros.svh =====
// ----------------------------------------------------------------------------
// Track associator assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GREEDY_NEAREST_TRACK_ASSOCIATOR_MACROS_SVH
`define GREEDY_NEAREST_TRACK_ASSOCIATOR_MACROS_SVH

// Check that a condition holds at every rising clock edge.
`define GNTA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Check that a consequent holds whenever an antecedent holds.
`define GNTA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/gnta_pkg.sv =====
// ----------------------------------------------------------------------------
// Track associator package
// Field widths, codes and the structs passed between the block's parts.
// ----------------------------------------------------------------------------
`default_nettype none

package gnta_pkg;

  localparam int COORD_W = 12;
  localparam int ID_W    = 16;
  localparam int MISS_W  = 8;
  localparam int FRM_W   = 13;
  localparam int MD_W    = 16;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;

  localparam int SQ_W    = 2 * COORD_W;
  localparam int FSQ_W   = 2 * FRM_W;
  localparam int PROD_W  = SQ_W + FSQ_W;
  localparam int DIST_W  = PROD_W + 1;
  localparam int MDW_W   = MD_W + FRM_W;
  localparam int R_W     = MD_W + 2 * FRM_W;
  localparam int RL_W    = R_W / 2;
  localparam int RH_W    = R_W - RL_W;
  localparam int RSQ_W   = 2 * R_W;
  localparam int FRAC_W  = 32;
  localparam int THR_W   = RSQ_W - FRAC_W;

  localparam logic [2:0]        SETTLE_CYC  = 3'd4;
  localparam logic [MISS_W-1:0] MISS_MAX    = '1;
  localparam logic [MISS_W-1:0] RST_MAXMISS = 8'd5;
  localparam logic [MD_W-1:0]   RST_MDIST   = 16'd6554;
  localparam logic [FRM_W-1:0]  RST_FWIDTH  = 13'd640;
  localparam logic [FRM_W-1:0]  RST_FHEIGHT = 13'd480;

  typedef enum logic [CIDX_W-1:0] {
    CFG_MAX_MISSED = 2'd0,
    CFG_MATCH_DIST = 2'd1,
    CFG_FRAME_W    = 2'd2,
    CFG_FRAME_H    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_ASSIGN = 2'd0,
    KIND_TRACK  = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DSCAN,
    ST_DDONE,
    ST_ESCAN,
    ST_EDONE
  } state_e;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [MISS_W-1:0]  missed;
  } slot_t;

  localparam int SLOT_W = ID_W + 4 * COORD_W + MISS_W;

  typedef struct packed {
    logic [MISS_W-1:0] max_missed;
    logic [FSQ_W-1:0]  w2;
    logic [FSQ_W-1:0]  h2;
    logic [THR_W-1:0]  thr;
    logic              low_nz;
    logic              ready;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic [ID_W-1:0]    track_id;
    logic               is_new;
    logic               table_full;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [MISS_W-1:0]  missed;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/gnta_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gnta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/gnta_front.sv =====
// ----------------------------------------------------------------------------
// Track associator front end
// Two-entry request queue between the command port and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module gnta_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gnta_pkg::item_t item_i,
  output logic           busy_o,
  input  logic           pop_i,
  output logic           valid_o,
  output gnta_pkg::item_t item_o
);
  import gnta_pkg::*;

  item_t      mem_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign busy_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !busy_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gnta_cfg.sv =====
// ----------------------------------------------------------------------------
// Track associator configuration
// Register file and the pipeline that derives the squared match radius.
// ----------------------------------------------------------------------------
`default_nettype none

module gnta_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gnta_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  logic [gnta_pkg::CFG_W-1:0]    cfg_wdata_i,
  output gnta_pkg::cfg_t                cfg_o
);
  import gnta_pkg::*;

  logic [MISS_W-1:0] maxm_q;
  logic [MD_W-1:0]   md_q;
  logic [FRM_W-1:0]  fw_q, fh_q;
  logic [2:0]        settle_q;

  logic [FSQ_W-1:0]  w2_q, h2_q;
  logic [MDW_W-1:0]  mdw_q;
  logic [R_W-1:0]    r_q;
  logic [2*RH_W-1:0] hh_q;
  logic [R_W-1:0]    hl_q;
  logic [2*RL_W-1:0] ll_q;
  logic [RSQ_W-1:0]  rsq_q;

  logic [FSQ_W-1:0]  w2_d, h2_d;
  logic [MDW_W-1:0]  mdw_d;
  logic [R_W-1:0]    r_d;
  logic [RH_W-1:0]   rh;
  logic [RL_W-1:0]   rl;
  logic [2*RH_W-1:0] hh_d;
  logic [R_W-1:0]    hl_d;
  logic [2*RL_W-1:0] ll_d;
  logic [RSQ_W-1:0]  rsq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxm_q   <= RST_MAXMISS;
      md_q     <= RST_MDIST;
      fw_q     <= RST_FWIDTH;
      fh_q     <= RST_FHEIGHT;
      settle_q <= SETTLE_CYC;
    end else begin
      if (cfg_we_i) begin
        settle_q <= SETTLE_CYC;
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MAX_MISSED: maxm_q <= cfg_wdata_i[MISS_W-1:0];
          CFG_MATCH_DIST: md_q   <= cfg_wdata_i[MD_W-1:0];
          CFG_FRAME_W:    fw_q   <= cfg_wdata_i[FRM_W-1:0];
          CFG_FRAME_H:    fh_q   <= cfg_wdata_i[FRM_W-1:0];
          default: ;
        endcase
      end else if (settle_q != 3'd0) begin
        settle_q <= settle_q - 3'd1;
      end
    end
  end

  // R = md * W * H, then R^2 from three half-width products
  assign w2_d  = fw_q * fw_q;
  assign h2_d  = fh_q * fh_q;
  assign mdw_d = md_q * fw_q;
  assign r_d   = mdw_q * fh_q;
  assign rh    = r_q[R_W-1:RL_W];
  assign rl    = r_q[RL_W-1:0];
  assign hh_d  = rh * rh;
  assign hl_d  = rh * rl;
  assign ll_d  = rl * rl;
  assign rsq_d = (RSQ_W'(hh_q) << (2 * RL_W)) + (RSQ_W'(hl_q) << (RL_W + 1))
               + RSQ_W'(ll_q);

  always_ff @(posedge clk_i) begin
    w2_q  <= w2_d;
    h2_q  <= h2_d;
    mdw_q <= mdw_d;
    r_q   <= r_d;
    hh_q  <= hh_d;
    hl_q  <= hl_d;
    ll_q  <= ll_d;
    rsq_q <= rsq_d;
  end

  assign cfg_o.max_missed = maxm_q;
  assign cfg_o.w2         = w2_q;
  assign cfg_o.h2         = h2_q;
  assign cfg_o.thr        = rsq_q[RSQ_W-1:FRAC_W];
  assign cfg_o.low_nz     = |rsq_q[FRAC_W-1:0];
  assign cfg_o.ready      = (settle_q == 3'd0);

endmodule

`default_nettype wire

// ===== sv/gnta_back.sv =====
// ----------------------------------------------------------------------------
// Track associator engine
// Scans the track table for detections and compacts it at end of frame.
// ----------------------------------------------------------------------------
`default_nettype none
`include "greedy_nearest_track_associator_macros.svh"

module gnta_back #(
  parameter int MAX_TRACKS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  gnta_pkg::item_t    item_i,
  output logic               item_pop_o,
  input  gnta_pkg::cfg_t     cfg_i,
  output logic               res_valid_o,
  output gnta_pkg::result_t  res_o
);
  import gnta_pkg::*;

  localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CNT_W = $clog2(MAX_TRACKS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TRACKS);

  state_e state_q, state_d;
  item_t  cur_q;
  logic [CNT_W-1:0]      n_q, iss_q, wr_q;
  logic [MAX_TRACKS-1:0] matched_q;
  logic [ID_W-1:0]       id_ctr_q;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  slot_t             ram_wdata;
  logic [SLOT_W-1:0] ram_rdata;
  slot_t             rd_slot;

  logic              s1_v_q, s1_m_q;
  logic [IDX_W-1:0]  s1_idx_q;
  logic              s2_v_q, s3_v_q;
  logic [IDX_W-1:0]  s2_idx_q, s3_idx_q;
  logic [ID_W-1:0]   s2_id_q, s3_id_q;
  logic [SQ_W-1:0]   s2_dx2_q, s2_dy2_q;
  logic [PROD_W-1:0] s3_hx_q, s3_vy_q;

  logic              found_q;
  logic [DIST_W-1:0] best_d_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [ID_W-1:0]   best_id_q;

  logic    pend_v_q;
  slot_t   pend_q;
  logic    res_v_q, res_v_d;
  result_t res_q, res_d;

  logic              issue, scan_end, keep, take;
  logic [COORD_W-1:0] dx, dy;
  logic [SQ_W-1:0]   dx2, dy2;
  logic [PROD_W-1:0] hx, vy;
  logic [DIST_W-1:0] dist_sum;
  logic [THR_W-1:0]  dist_ext;
  logic              in_radius;
  logic [MISS_W-1:0] e_miss;
  slot_t             kept;

  function automatic result_t report(slot_t s, logic lst);
    result_t r;
    r            = '0;
    r.kind       = KIND_TRACK;
    r.track_id   = s.id;
    r.x          = s.x;
    r.y          = s.y;
    r.w          = s.w;
    r.h          = s.h;
    r.missed     = s.missed;
    r.last       = lst;
    return r;
  endfunction

  gnta_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_TRACKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (iss_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_slot = slot_t'(ram_rdata);

  // distance pipe: abs and square, then frame weighting, then compare
  assign dx   = (cur_q.x >= rd_slot.x) ? cur_q.x - rd_slot.x : rd_slot.x - cur_q.x;
  assign dy   = (cur_q.y >= rd_slot.y) ? cur_q.y - rd_slot.y : rd_slot.y - cur_q.y;
  assign dx2  = dx * dx;
  assign dy2  = dy * dy;
  assign hx   = s2_dx2_q * cfg_i.h2;
  assign vy   = s2_dy2_q * cfg_i.w2;
  assign dist_sum  = DIST_W'(s3_hx_q) + DIST_W'(s3_vy_q);
  assign dist_ext  = THR_W'(dist_sum);
  assign in_radius = (dist_ext < cfg_i.thr) || (dist_ext == cfg_i.thr && cfg_i.low_nz);
  assign take      = s3_v_q && in_radius && (!found_q || dist_sum < best_d_q);

  // aging: matched tracks hold their count, others advance and saturate
  assign e_miss = s1_m_q ? rd_slot.missed :
                  (rd_slot.missed == MISS_MAX) ? MISS_MAX : rd_slot.missed + 1'b1;
  assign keep   = e_miss <= cfg_i.max_missed;
  always_comb begin
    kept        = rd_slot;
    kept.missed = e_miss;
  end

  assign issue    = (iss_q < n_q);
  assign scan_end = !issue && !s1_v_q && !s2_v_q && !s3_v_q;

  always_comb begin
    state_d    = state_q;
    item_pop_o = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = best_idx_q;
    ram_wdata  = '0;
    res_v_d    = 1'b0;
    res_d      = '0;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i && (item_i.action || cfg_i.ready)) begin
          item_pop_o = 1'b1;
          state_d    = item_i.action ? ST_ESCAN : ST_DSCAN;
        end
      end
      ST_DSCAN: begin
        ram_re = issue;
        if (scan_end) state_d = ST_DDONE;
      end
      ST_DDONE: begin
        res_v_d       = 1'b1;
        res_d.kind    = KIND_ASSIGN;
        res_d.last    = 1'b1;
        ram_wdata.x   = cur_q.x;
        ram_wdata.y   = cur_q.y;
        ram_wdata.w   = cur_q.w;
        ram_wdata.h   = cur_q.h;
        if (found_q) begin
          ram_we       = 1'b1;
          ram_wdata.id = best_id_q;
        end else if (n_q < FULL_CNT) begin
          ram_we       = 1'b1;
          ram_waddr    = n_q[IDX_W-1:0];
          ram_wdata.id = id_ctr_q;
          res_d.is_new = 1'b1;
        end else begin
          res_d.table_full = 1'b1;
        end
        if (ram_we) begin
          res_d.track_id = ram_wdata.id;
          res_d.x        = cur_q.x;
          res_d.y        = cur_q.y;
          res_d.w        = cur_q.w;
          res_d.h        = cur_q.h;
        end
        state_d = ST_IDLE;
      end
      ST_ESCAN: begin
        ram_re = issue;
        if (s1_v_q && keep) begin
          // write the survivor down into its compacted slot
          ram_we    = 1'b1;
          ram_waddr = wr_q[IDX_W-1:0];
          ram_wdata = kept;
          if (pend_v_q) begin
            res_v_d = 1'b1;
            res_d   = report(pend_q, 1'b0);
          end
        end
        if (scan_end) state_d = ST_EDONE;
      end
      ST_EDONE: begin
        res_v_d = 1'b1;
        if (pend_v_q) begin
          res_d = report(pend_q, 1'b1);
        end else begin
          res_d.kind = KIND_EMPTY;
          res_d.last = 1'b1;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      n_q       <= '0;
      iss_q     <= '0;
      wr_q      <= '0;
      matched_q <= '0;
      id_ctr_q  <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      found_q   <= 1'b0;
      pend_v_q  <= 1'b0;
      res_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      res_v_q <= res_v_d;
      s1_v_q  <= ram_re;
      s2_v_q  <= s1_v_q && !s1_m_q && (state_q == ST_DSCAN);
      s3_v_q  <= s2_v_q;
      if (item_pop_o) begin
        iss_q    <= '0;
        wr_q     <= '0;
        found_q  <= 1'b0;
        pend_v_q <= 1'b0;
      end
      if (ram_re) iss_q <= iss_q + 1'b1;
      if (take) found_q <= 1'b1;
      if (state_q == ST_DDONE) begin
        if (found_q) begin
          matched_q[best_idx_q] <= 1'b1;
        end else if (n_q < FULL_CNT) begin
          matched_q[n_q[IDX_W-1:0]] <= 1'b1;
          n_q      <= n_q + 1'b1;
          id_ctr_q <= id_ctr_q + 1'b1;
        end
      end
      if (state_q == ST_ESCAN && s1_v_q && keep) begin
        wr_q     <= wr_q + 1'b1;
        pend_v_q <= 1'b1;
      end
      if (state_q == ST_EDONE) begin
        n_q       <= wr_q;
        matched_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) cur_q <= item_i;
    if (ram_re) begin
      s1_idx_q <= iss_q[IDX_W-1:0];
      s1_m_q   <= matched_q[iss_q[IDX_W-1:0]];
    end
    s2_idx_q <= s1_idx_q;
    s2_id_q  <= rd_slot.id;
    s2_dx2_q <= dx2;
    s2_dy2_q <= dy2;
    s3_idx_q <= s2_idx_q;
    s3_id_q  <= s2_id_q;
    s3_hx_q  <= hx;
    s3_vy_q  <= vy;
    if (take) begin
      best_d_q   <= dist_sum;
      best_idx_q <= s3_idx_q;
      best_id_q  <= s3_id_q;
    end
    if (state_q == ST_ESCAN && s1_v_q && keep) pend_q <= kept;
    res_q <= res_d;
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  `GNTA_ASSERT(fill_in_range, n_q <= FULL_CNT, "track count above table size")
  `GNTA_ASSERT_IMP(full_flag_at_capacity, res_v_q && res_q.table_full, n_q == FULL_CNT, "table_full with free slot")
  `GNTA_ASSERT_IMP(new_track_grows, res_v_q && res_q.is_new, n_q == $past(n_q) + 1'b1, "new track without slot")
  `GNTA_ASSERT_IMP(empty_means_no_tracks, res_v_q && res_q.kind == KIND_EMPTY, n_q == '0, "empty marker with tracks left")
  `GNTA_ASSERT_IMP(compact_behind_scan, state_q == ST_ESCAN, wr_q <= iss_q, "compaction write ahead of scan")

endmodule

`default_nettype wire

// ===== sv/greedy_nearest_track_associator.sv =====
// ----------------------------------------------------------------------------
// Greedy nearest track associator
// Keeps a table of object tracks, assigns detections to the nearest free
// track and ages, prunes and reports the table at each end of frame.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start high and busy low, and
// goes into a two-entry queue, so a new request can be taken while the engine
// works; busy rises only when that queue is full. Results appear on the
// result ports for exactly one cycle, marked by res_valid_o, and the receiver
// cannot stall them. A detection reads all n valid tracks one slot a cycle
// through the track RAM's single read port, followed by a three-stage distance
// pipe (abs and square, frame weighting, compare); the engine takes the next
// request in the cycle its result shows. An end-of-frame request reads and
// compacts the table in one pass and reports each survivor as the next one is
// found; its last report (or the empty marker) has last_o set. After reset and
// after each register write the squared match radius has to settle; detections
// wait for it while end-of-frame requests do not. Registers must be written
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_nearest_track_associator #(
  parameter int MAX_TRACKS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action_i,
  input  logic [gnta_pkg::COORD_W-1:0]    det_x_i,
  input  logic [gnta_pkg::COORD_W-1:0]    det_y_i,
  input  logic [gnta_pkg::COORD_W-1:0]    det_w_i,
  input  logic [gnta_pkg::COORD_W-1:0]    det_h_i,
  input  logic                            cfg_we_i,
  input  logic [gnta_pkg::CIDX_W-1:0]     cfg_idx_i,
  input  logic [gnta_pkg::CFG_W-1:0]      cfg_wdata_i,
  output logic                            res_valid_o,
  output logic [1:0]                      kind_o,
  output logic [gnta_pkg::ID_W-1:0]       track_id_o,
  output logic                            is_new_o,
  output logic                            table_full_o,
  output logic [gnta_pkg::COORD_W-1:0]    out_x_o,
  output logic [gnta_pkg::COORD_W-1:0]    out_y_o,
  output logic [gnta_pkg::COORD_W-1:0]    out_w_o,
  output logic [gnta_pkg::COORD_W-1:0]    out_h_o,
  output logic [gnta_pkg::MISS_W-1:0]     frames_missed_o,
  output logic                            last_o
);
  import gnta_pkg::*;

  item_t   in_item, q_item;
  logic    q_valid, q_pop;
  cfg_t    cfg;
  result_t res;

  // pack the request fields as they arrive
  assign in_item.action = action_i;
  assign in_item.x      = det_x_i;
  assign in_item.y      = det_y_i;
  assign in_item.w      = det_w_i;
  assign in_item.h      = det_h_i;

  // front: hold up to two requests while the engine is busy
  gnta_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start),
    .item_i  (in_item),
    .busy_o  (busy),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // registers and the derived radius threshold
  gnta_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // back: association scan and end-of-frame compaction
  gnta_back #(
    .MAX_TRACKS (MAX_TRACKS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .cfg_i        (cfg),
    .res_valid_o  (res_valid_o),
    .res_o        (res)
  );

  // drive the result ports straight from the engine's output register
  assign kind_o          = res.kind;
  assign track_id_o      = res.track_id;
  assign is_new_o        = res.is_new;
  assign table_full_o    = res.table_full;
  assign out_x_o         = res.x;
  assign out_y_o         = res.y;
  assign out_w_o         = res.w;
  assign out_h_o         = res.h;
  assign frames_missed_o = res.missed;
  assign last_o          = res.last;

endmodule

`default_nettype wire

// ===== tb/tb_greedy_nearest_track_associator.sv =====
// ----------------------------------------------------------------------------
// Track associator testbench
// Drives detection and end-of-frame requests into the track associator and
// checks every result against a cycle-free model of the track table.
// A short directed table comes first, then directed overflow and missed-count
// runs, then random frames under several register settings and sender idle rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_greedy_nearest_track_associator;
  import gnta_pkg::*;

  localparam int NUM_SLOTS   = 16;
  localparam int DRAIN_CYC   = 40;    // longest detection scan plus margin
  localparam int STALL_LIMIT = 4000;  // cycles without any transfer

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic               known;
    result_t            known_res;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               action_i;
  logic [COORD_W-1:0] det_x_i, det_y_i, det_w_i, det_h_i;
  logic               cfg_we_i;
  logic [CIDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]   cfg_wdata_i;
  logic               res_valid_o;
  logic [1:0]         kind_o;
  logic [ID_W-1:0]    track_id_o;
  logic               is_new_o, table_full_o, last_o;
  logic [COORD_W-1:0] out_x_o, out_y_o, out_w_o, out_h_o;
  logic [MISS_W-1:0]  frames_missed_o;

  // Directed rows may carry a hand-written expectation for their one result.
  logic    cur_known;
  result_t cur_known_res;

  greedy_nearest_track_associator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .det_x_i        (det_x_i),
    .det_y_i        (det_y_i),
    .det_w_i        (det_w_i),
    .det_h_i        (det_h_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .res_valid_o    (res_valid_o),
    .kind_o         (kind_o),
    .track_id_o     (track_id_o),
    .is_new_o       (is_new_o),
    .table_full_o   (table_full_o),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .out_w_o        (out_w_o),
    .out_h_o        (out_h_o),
    .frames_missed_o(frames_missed_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Track table model: own copy of the slots and registers
  // --------------------------------------------------------------------------
  logic               trk_valid   [NUM_SLOTS];
  logic               trk_matched [NUM_SLOTS];
  logic [ID_W-1:0]    trk_id      [NUM_SLOTS];
  logic [COORD_W-1:0] trk_x       [NUM_SLOTS];
  logic [COORD_W-1:0] trk_y       [NUM_SLOTS];
  logic [COORD_W-1:0] trk_w       [NUM_SLOTS];
  logic [COORD_W-1:0] trk_h       [NUM_SLOTS];
  logic [MISS_W-1:0]  trk_missed  [NUM_SLOTS];
  logic [ID_W-1:0]    next_track_id;

  logic [MISS_W-1:0]  keep_limit;
  logic [MD_W-1:0]    radius_q16;
  logic [FRM_W-1:0]   frm_w, frm_h;

  result_t expected_results[$];
  int      mismatches;
  int      idle_pct;
  int      stall_cycles;

  // Append one result to the tail of the expectation queue.
  function automatic void enqueue_result(result_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic result_t make_result(kind_e k, logic [ID_W-1:0] id, logic nw,
                                          logic full, logic [COORD_W-1:0] x,
                                          logic [COORD_W-1:0] y,
                                          logic [COORD_W-1:0] w,
                                          logic [COORD_W-1:0] h,
                                          logic [MISS_W-1:0] miss, logic lst);
    result_t r;
    r.kind       = k;
    r.track_id   = id;
    r.is_new     = nw;
    r.table_full = full;
    r.x          = x;
    r.y          = y;
    r.w          = w;
    r.h          = h;
    r.missed     = miss;
    r.last       = lst;
    return r;
  endfunction

  // Nearest unmatched track strictly inside the radius, else open a track.
  function automatic void associate_detection(logic [COORD_W-1:0] x,
                                              logic [COORD_W-1:0] y,
                                              logic [COORD_W-1:0] w,
                                              logic [COORD_W-1:0] h);
    logic [127:0]       rad, rad_sq, dist_sq, best;
    logic [COORD_W-1:0] dx, dy;
    int                 hit;
    hit    = -1;
    best   = '0;
    rad    = 128'(radius_q16) * frm_w * frm_h;
    rad_sq = rad * rad;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (trk_valid[i] && !trk_matched[i]) begin
        dx      = (x >= trk_x[i]) ? x - trk_x[i] : trk_x[i] - x;
        dy      = (y >= trk_y[i]) ? y - trk_y[i] : trk_y[i] - y;
        dist_sq = 128'(dx) * dx * frm_h * frm_h + 128'(dy) * dy * frm_w * frm_w;
        if (((dist_sq << 32) < rad_sq) && (hit < 0 || dist_sq < best)) begin
          best = dist_sq;
          hit  = i;
        end
      end
    end
    if (hit < 0) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (hit < 0 && !trk_valid[i]) begin
          hit          = i;
          trk_valid[i] = 1'b1;
          trk_id[i]    = next_track_id;
          next_track_id++;
        end
      end
      if (hit < 0) begin
        enqueue_result(make_result(KIND_ASSIGN, '0, 1'b0, 1'b1,
                                   '0, '0, '0, '0, '0, 1'b1));
        return;
      end
      enqueue_result(make_result(KIND_ASSIGN, trk_id[hit], 1'b1, 1'b0,
                                 x, y, w, h, '0, 1'b1));
    end else begin
      enqueue_result(make_result(KIND_ASSIGN, trk_id[hit], 1'b0, 1'b0,
                                 x, y, w, h, '0, 1'b1));
    end
    trk_x[hit]       = x;
    trk_y[hit]       = y;
    trk_w[hit]       = w;
    trk_h[hit]       = h;
    trk_missed[hit]  = '0;
    trk_matched[hit] = 1'b1;
  endfunction

  // Age unmatched tracks, compact out the stale ones, report the rest.
  function automatic void close_frame();
    int n;
    n = 0;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (trk_valid[i] && !trk_matched[i] && trk_missed[i] != MISS_MAX)
        trk_missed[i]++;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (trk_valid[i] && trk_missed[i] <= keep_limit) begin
        trk_id[n]     = trk_id[i];
        trk_x[n]      = trk_x[i];
        trk_y[n]      = trk_y[i];
        trk_w[n]      = trk_w[i];
        trk_h[n]      = trk_h[i];
        trk_missed[n] = trk_missed[i];
        trk_valid[n]  = 1'b1;
        n++;
      end
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (i >= n) trk_valid[i] = 1'b0;
      trk_matched[i] = 1'b0;
    end
    if (n == 0)
      enqueue_result(make_result(KIND_EMPTY, '0, 1'b0, 1'b0,
                                 '0, '0, '0, '0, '0, 1'b1));
    for (int i = 0; i < n; i++)
      enqueue_result(make_result(KIND_TRACK, trk_id[i], 1'b0, 1'b0,
                                 trk_x[i], trk_y[i], trk_w[i], trk_h[i],
                                 trk_missed[i], i == n - 1));
  endfunction

  // --------------------------------------------------------------------------
  // Predict on every accepted request
  // --------------------------------------------------------------------------
  int depth_at_accept;

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      depth_at_accept = expected_results.size();
      if (action_i) close_frame();
      else associate_detection(det_x_i, det_y_i, det_w_i, det_h_i);
      // A hand-written expectation replaces the single predicted result.
      if (cur_known) expected_results[depth_at_accept] = cur_known_res;
    end
  end

  // --------------------------------------------------------------------------
  // Check every result strobe against the oldest expectation
  // --------------------------------------------------------------------------
  result_t seen, want;

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      seen = make_result(kind_e'(kind_o), track_id_o, is_new_o, table_full_o,
                         out_x_o, out_y_o, out_w_o, out_h_o, frames_missed_o, last_o);
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: %p", seen);
      end else begin
        want = expected_results.pop_front();
        if (seen.kind !== want.kind || seen.track_id !== want.track_id ||
            seen.is_new !== want.is_new || seen.table_full !== want.table_full ||
            seen.x !== want.x || seen.y !== want.y || seen.w !== want.w ||
            seen.h !== want.h || seen.missed !== want.missed ||
            seen.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at %0t: expected %p actual %p", $realtime, want, seen);
        end
      end
    end
  end

  // Watchdog: count cycles in which nothing moves.
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o || cfg_we_i || !rst_ni) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Hold the request until taken, then drop start for a random gap or keep it.
  task automatic send_request(logic act, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [COORD_W-1:0] w, logic [COORD_W-1:0] h,
                              logic known, result_t kres);
    start         <= 1'b1;
    action_i      <= act;
    det_x_i       <= x;
    det_y_i       <= y;
    det_w_i       <= w;
    det_h_i       <= h;
    cur_known     <= known;
    cur_known_res <= kres;
    do @(posedge clk_i); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start     <= 1'b0;
      cur_known <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic send_plain(logic act, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COORD_W-1:0] w, logic [COORD_W-1:0] h);
    send_request(act, x, y, w, h, 1'b0, '0);
  endtask

  // Stop sending and wait for every outstanding result, then let the engine settle.
  task automatic drain();
    start     <= 1'b0;
    cur_known <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  // Write all four registers while idle; mirror the masked values.
  task automatic set_config(logic [CFG_W-1:0] mm, logic [CFG_W-1:0] md,
                            logic [CFG_W-1:0] fw, logic [CFG_W-1:0] fh);
    cfg_idx_e   idx_list [4];
    logic [CFG_W-1:0] val_list [4];
    idx_list = '{CFG_MAX_MISSED, CFG_MATCH_DIST, CFG_FRAME_W, CFG_FRAME_H};
    val_list = '{mm, md, fw, fh};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx_list[i];
      cfg_wdata_i <= val_list[i];
      @(posedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    keep_limit = mm[MISS_W-1:0];
    radius_q16 = md[MD_W-1:0];
    frm_w      = fw[FRM_W-1:0];
    frm_h      = fh[FRM_W-1:0];
    @(posedge clk_i);
  endtask

  // Random frames: mostly detections near live tracks, some anywhere,
  // end of frame about one request in four.
  task automatic random_frames(int count);
    int live, pick, px, py;
    logic [COORD_W-1:0] rx, ry;
    for (int k = 0; k < count; k++) begin
      live = 0;
      for (int i = 0; i < NUM_SLOTS; i++) if (trk_valid[i]) live++;
      if ($urandom_range(99) < 25) begin
        send_plain(1'b1, COORD_W'($urandom), COORD_W'($urandom),
                   COORD_W'($urandom), COORD_W'($urandom));
      end else if (live > 0 && $urandom_range(99) < 65) begin
        pick = $urandom_range(live - 1);
        px   = int'(trk_x[pick]) + $urandom_range(80) - 40;
        py   = int'(trk_y[pick]) + $urandom_range(80) - 40;
        px   = (px < 0) ? 0 : (px > 4095) ? 4095 : px;
        py   = (py < 0) ? 0 : (py > 4095) ? 4095 : py;
        send_plain(1'b0, COORD_W'(px), COORD_W'(py),
                   COORD_W'($urandom), COORD_W'($urandom));
      end else begin
        rx = ($urandom_range(9) == 0) ? '1 : COORD_W'($urandom);
        ry = ($urandom_range(9) == 0) ? '0 : COORD_W'($urandom);
        send_plain(1'b0, rx, ry, COORD_W'($urandom), COORD_W'($urandom));
      end
    end
  endtask

  stim_row_t directed_rows[$];

  task automatic add_row(logic act, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                         logic [COORD_W-1:0] w, logic [COORD_W-1:0] h,
                         logic known, result_t kres);
    stim_row_t r;
    r.action    = act;
    r.x         = x;
    r.y         = y;
    r.w         = w;
    r.h         = h;
    r.known     = known;
    r.known_res = kres;
    directed_rows = {directed_rows, r};
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    action_i      = 1'b0;
    det_x_i       = '0;
    det_y_i       = '0;
    det_w_i       = '0;
    det_h_i       = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_MAX_MISSED;
    cfg_wdata_i   = '0;
    cur_known     = 1'b0;
    cur_known_res = '0;
    mismatches    = 0;
    stall_cycles  = 0;
    idle_pct      = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      trk_valid[i]   = 1'b0;
      trk_matched[i] = 1'b0;
      trk_id[i]      = '0;
      trk_x[i]       = '0;
      trk_y[i]       = '0;
      trk_w[i]       = '0;
      trk_h[i]       = '0;
      trk_missed[i]  = '0;
    end
    next_track_id = '0;
    keep_limit    = RST_MAXMISS;
    radius_q16    = RST_MDIST;
    frm_w         = RST_FWIDTH;
    frm_h         = RST_FHEIGHT;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at reset settings (640x480, radius about 0.1).
    add_row(1'b1, 0, 0, 0, 0, 1'b1,
            make_result(KIND_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    add_row(1'b0, 0, 0, 0, 0, 1'b1,
            make_result(KIND_ASSIGN, 0, 1, 0, 0, 0, 0, 0, 0, 1));
    add_row(1'b0, '1, '1, '1, '1, 1'b1,
            make_result(KIND_ASSIGN, 1, 1, 0, '1, '1, '1, '1, 0, 1));
    // Same spot again: the track there is already matched this frame.
    add_row(1'b0, 0, 0, 5, 5, 1'b1,
            make_result(KIND_ASSIGN, 2, 1, 0, 0, 0, 5, 5, 0, 1));
    add_row(1'b1, 0, 0, 0, 0, 1'b0, '0);
    // Equal distance to two tracks: lowest slot wins, then the other one.
    add_row(1'b0, 3, 3, 10, 10, 1'b0, '0);
    add_row(1'b0, 3, 3, 11, 11, 1'b0, '0);
    add_row(1'b0, 4090, 4090, 1, 2, 1'b0, '0);
    add_row(1'b0, 2000, 1000, 2048, 1024, 1'b0, '0);
    add_row(1'b1, 0, 0, 0, 0, 1'b0, '0);
    add_row(1'b1, 0, 0, 0, 0, 1'b0, '0);
    add_row(1'b0, 2010, 1005, 7, 7, 1'b0, '0);
    add_row(1'b0, 2730, 1365, 1365, 2730, 1'b0, '0);
    add_row(1'b1, 0, 0, 0, 0, 1'b0, '0);
    foreach (directed_rows[i])
      send_request(directed_rows[i].action, directed_rows[i].x, directed_rows[i].y,
                   directed_rows[i].w, directed_rows[i].h,
                   directed_rows[i].known, directed_rows[i].known_res);
    drain();

    // Clear the table, then fill it with zero frame width until it overflows.
    set_config(0, 6554, 0, 480);
    send_plain(1'b1, 0, 0, 0, 0);
    send_plain(1'b1, 0, 0, 0, 0);
    for (int i = 0; i < NUM_SLOTS + 2; i++)
      send_plain(1'b0, 100, 100, COORD_W'(i), COORD_W'(i));
    send_plain(1'b1, 0, 0, 0, 0);
    send_plain(1'b1, 0, 0, 0, 0);
    drain();

    // Keep limit at the full 8-bit range: the missed count climbs each frame.
    set_config(255, 0, 640, 0);
    send_plain(1'b0, 321, 123, 9, 9);
    for (int i = 0; i < 8; i++) send_plain(1'b1, 0, 0, 0, 0);
    drain();
    set_config(0, 0, 1, 1);
    send_plain(1'b1, 0, 0, 0, 0);
    drain();

    // Random phases across settings and sender idle rates.
    idle_pct = 0;
    set_config(RST_MAXMISS, RST_MDIST, RST_FWIDTH, RST_FHEIGHT);
    random_frames(20);
    drain();

    idle_pct = 68;
    set_config(0, 16'hFFFF, 4096, 4096);
    random_frames(15);
    drain();

    idle_pct = 19;
    set_config(254, 0, 1, 1);
    random_frames(15);
    drain();

    idle_pct = 68;
    set_config(2, 3000, 1, 4096);
    random_frames(12);
    drain();

    idle_pct = 0;
    set_config(1, 20000, 4096, 1);
    random_frames(12);
    drain();

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/gnta_pkg.sv
sv/gnta_ram.sv
sv/gnta_front.sv
sv/gnta_cfg.sv
sv/gnta_back.sv
sv/greedy_nearest_track_associator.sv
tb/tb_greedy_nearest_track_associator.sv
